// ===== rtl/core/skl_pkg.sv =====
// skl_pkg: shared widths, request and status codes, cell control types
// for the sorted key list. No dependencies.
`default_nettype none

package skl_pkg;

    localparam int KEY_W  = 32;
    localparam int ITEM_W = 32;
    localparam int OP_W   = 3;
    localparam int STAT_W = 3;

    // request codes
    localparam logic [OP_W-1:0] REQ_PREPEND = 3'd0;
    localparam logic [OP_W-1:0] REQ_APPEND  = 3'd1;
    localparam logic [OP_W-1:0] REQ_POP     = 3'd2;
    localparam logic [OP_W-1:0] REQ_INSERT  = 3'd3;
    localparam logic [OP_W-1:0] REQ_REMOVE  = 3'd4;

    // status codes
    localparam logic [STAT_W-1:0] ST_OK        = 3'd0;
    localparam logic [STAT_W-1:0] ST_EMPTY     = 3'd1;
    localparam logic [STAT_W-1:0] ST_NOT_FOUND = 3'd2;
    localparam logic [STAT_W-1:0] ST_FULL      = 3'd3;
    localparam logic [STAT_W-1:0] ST_OVERFLOW  = 3'd4;

    localparam logic signed [KEY_W-1:0] KEY_MIN = 32'sh8000_0000;
    localparam logic signed [KEY_W-1:0] KEY_MAX = 32'sh7FFF_FFFF;

    // how the row moves in the execute cycle
    typedef enum logic [2:0] {
        MD_NONE,       // hold
        MD_INS_ALL,    // insert at the head
        MD_INS_END,    // insert after the tail
        MD_INS_SORT,   // insert after the entries below the key (never at the head)
        MD_DEL_ALL,    // delete the head
        MD_DEL_LAST,   // delete the tail
        MD_DEL_FIRST   // delete the first entry not below the key
    } t_mode;

    // broadcast to every cell
    typedef struct packed {
        t_mode                     mode;
        logic signed [KEY_W-1:0]   key;
        logic [ITEM_W-1:0]         item;
    } t_cell_ctl;

    // compare flags of one cell against the request key, masked by valid
    typedef struct packed {
        logic lt;
        logic eq;
        logic gt;
    } t_cell_flags;

endpackage

`default_nettype wire

// ===== rtl/core/skl_if.sv =====
// skl_req_if / skl_rsp_if: valid/ready channels of the sorted key list.
// Depends on skl_pkg.
`default_nettype none

interface skl_req_if;
    import skl_pkg::*;

    logic                     valid;
    logic                     ready;
    logic [OP_W-1:0]          req_type;
    logic [ITEM_W-1:0]        item_handle;
    logic signed [KEY_W-1:0]  req_key;

    modport source (output valid, output req_type, output item_handle, output req_key,
                    input ready);
    modport sink   (input valid, input req_type, input item_handle, input req_key,
                    output ready);
endinterface

interface skl_rsp_if;
    import skl_pkg::*;

    logic                     valid;
    logic                     ready;
    logic [STAT_W-1:0]        status;
    logic [ITEM_W-1:0]        out_item;
    logic signed [KEY_W-1:0]  out_key;

    modport source (output valid, output status, output out_item, output out_key,
                    input ready);
    modport sink   (input valid, input status, input out_item, input out_key,
                    output ready);
endinterface

`default_nettype wire

// ===== rtl/core/skl_cell.sv =====
// skl_cell: one slot of the sorted row. Holds a key and an item, compares
// against the request key, and shifts toward or away from its neighbors.
// Depends on skl_pkg.
`default_nettype none

module skl_cell (
    input  wire logic                             i_clk,
    input  wire logic                             i_cmp_en,
    input  wire logic signed [skl_pkg::KEY_W-1:0] i_cmp_key,
    input  wire logic                             i_valid,
    input  wire skl_pkg::t_cell_ctl               i_ctl,
    input  wire logic                             i_head,
    input  wire logic signed [skl_pkg::KEY_W-1:0] i_left_key,
    input  wire logic [skl_pkg::ITEM_W-1:0]       i_left_item,
    input  wire logic                             i_left_aoa,
    input  wire logic signed [skl_pkg::KEY_W-1:0] i_right_key,
    input  wire logic [skl_pkg::ITEM_W-1:0]       i_right_item,
    input  wire logic                             i_right_valid,
    output logic signed [skl_pkg::KEY_W-1:0]      o_key,
    output logic [skl_pkg::ITEM_W-1:0]            o_item,
    output skl_pkg::t_cell_flags                  o_flags,
    output logic                                  o_aoa
);
    import skl_pkg::*;

    logic signed [KEY_W-1:0] r_key, n_key;
    logic [ITEM_W-1:0]       r_item, n_item;
    t_cell_flags             r_flags;
    logic                    aoa;
    logic                    is_pos;

    // this slot is at or after the position the operation works on;
    // the head never takes a sorted insert
    always_comb begin
        unique case (i_ctl.mode)
            MD_INS_ALL:   aoa = 1'b1;
            MD_INS_END:   aoa = !i_valid;
            MD_INS_SORT:  aoa = !i_head && !r_flags.lt;
            MD_DEL_ALL:   aoa = 1'b1;
            MD_DEL_LAST:  aoa = !i_right_valid;
            MD_DEL_FIRST: aoa = !r_flags.lt;
            default:      aoa = 1'b0;
        endcase
    end

    assign is_pos = aoa && !i_left_aoa;

    // next contents
    always_comb begin
        n_key  = r_key;
        n_item = r_item;
        case (i_ctl.mode)
            MD_INS_ALL, MD_INS_END, MD_INS_SORT: begin
                if (is_pos) begin
                    n_key  = i_ctl.key;
                    n_item = i_ctl.item;
                end else if (aoa) begin
                    n_key  = i_left_key;
                    n_item = i_left_item;
                end
            end
            MD_DEL_ALL, MD_DEL_LAST, MD_DEL_FIRST: begin
                if (aoa) begin
                    n_key  = i_right_key;
                    n_item = i_right_item;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_key  <= n_key;
        r_item <= n_item;
        // flags sampled when the request is taken
        if (i_cmp_en) begin
            r_flags.lt <= i_valid && (r_key < i_cmp_key);
            r_flags.eq <= i_valid && (r_key == i_cmp_key);
            r_flags.gt <= i_valid && (r_key > i_cmp_key);
        end
    end

    assign o_key   = r_key;
    assign o_item  = r_item;
    assign o_flags = r_flags;
    assign o_aoa   = aoa;

endmodule

`default_nettype wire

// ===== rtl/core/sorted_key_list.sv =====
// sorted_key_list: top level. A row of skl_cell slots kept in ascending
// key order, plus the request decoder, entry count and response register.
// Depends on skl_pkg, skl_if and skl_cell.
//
// Usage:
//   i_req carries one request item (req_type, item_handle, req_key); it is
//   taken on a rising edge with valid and ready high. o_rsp carries one
//   response item (status, out_item, out_key) per request, in order.
//   Every slot compares its key with req_key on the accept edge; once the
//   output register is free, the decoder picks a move for the whole row
//   (insert at head, tail or sorted place, delete head, tail or first
//   match) and all slots shift at once, while the response is loaded into
//   the output register. A new request is not accepted until the previous
//   request has shifted the slot row. A finished response may wait in the
//   output register while the next request is accepted; that request's
//   shift waits until the output register is free, so a stalled receiver
//   holds the row and blocks further requests. Reset empties the list and
//   drops any response; slot contents are not cleared.
`default_nettype none

module sorted_key_list #(
    parameter int CAPACITY = 16
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    skl_req_if.sink   i_req,
    skl_rsp_if.source o_rsp
);
    import skl_pkg::*;

    localparam int CNT_W = $clog2(CAPACITY + 1);

    // request register
    logic                    r_busy;
    logic [OP_W-1:0]         r_op;
    logic [ITEM_W-1:0]       r_item;
    logic signed [KEY_W-1:0] r_key;
    logic [CNT_W-1:0]        r_count, n_count;

    // response register
    logic                    r_out_valid;
    logic [STAT_W-1:0]       r_status, n_status;
    logic [ITEM_W-1:0]       r_out_item, n_out_item;
    logic signed [KEY_W-1:0] r_out_key, n_out_key;

    logic accept;
    logic exec;

    // slot row wiring
    logic signed [KEY_W-1:0] cell_key  [CAPACITY];
    logic [ITEM_W-1:0]       cell_item [CAPACITY];
    t_cell_flags             cell_flags[CAPACITY];
    logic [CAPACITY-1:0]     cell_aoa;
    logic [CAPACITY-1:0]     valid;
    logic [CAPACITY-1:0]     is_tail;
    logic [CAPACITY-1:0]     first_eq;
    logic [CAPACITY-1:0]     gt_vec;
    logic [CAPACITY-1:0]     eq_vec;
    t_cell_ctl               ctl;

    logic signed [KEY_W-1:0] tail_key, match_key;
    logic [ITEM_W-1:0]       tail_item, match_item;
    logic                    tail_eq;
    logic                    empty, full;

    // no item is taken while reset is held
    assign accept = i_req.valid && i_rst_n && !r_busy;
    assign exec   = r_busy && (!r_out_valid || o_rsp.ready);
    assign i_req.ready = i_rst_n && !r_busy;

    // slots
    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        logic signed [KEY_W-1:0] left_key, right_key;
        logic [ITEM_W-1:0]       left_item, right_item;
        logic                    left_aoa, right_valid;

        assign valid[g]  = CNT_W'(g) < r_count;
        assign gt_vec[g] = cell_flags[g].gt;
        assign eq_vec[g] = cell_flags[g].eq;

        if (g == 0) begin : g_head
            assign left_key    = '0;
            assign left_item   = '0;
            assign left_aoa    = 1'b0;
            assign first_eq[g] = cell_flags[g].eq;
        end else begin : g_mid
            assign left_key    = cell_key[g-1];
            assign left_item   = cell_item[g-1];
            assign left_aoa    = cell_aoa[g-1];
            assign first_eq[g] = cell_flags[g].eq && !cell_flags[g-1].eq;
        end

        if (g == CAPACITY - 1) begin : g_last
            assign right_key   = '0;
            assign right_item  = '0;
            assign right_valid = 1'b0;
            assign is_tail[g]  = valid[g];
        end else begin : g_inner
            assign right_key   = cell_key[g+1];
            assign right_item  = cell_item[g+1];
            assign right_valid = valid[g+1];
            assign is_tail[g]  = valid[g] && !valid[g+1];
        end

        skl_cell u_cell (
            .i_clk         (i_clk),
            .i_cmp_en      (accept),
            .i_cmp_key     (i_req.req_key),
            .i_valid       (valid[g]),
            .i_ctl         (ctl),
            .i_head        (g == 0),
            .i_left_key    (left_key),
            .i_left_item   (left_item),
            .i_left_aoa    (left_aoa),
            .i_right_key   (right_key),
            .i_right_item  (right_item),
            .i_right_valid (right_valid),
            .o_key         (cell_key[g]),
            .o_item        (cell_item[g]),
            .o_flags       (cell_flags[g]),
            .o_aoa         (cell_aoa[g])
        );
    end

    // tail and first-match selection (one-hot AND-OR)
    always_comb begin
        tail_key   = '0;
        tail_item  = '0;
        tail_eq    = 1'b0;
        match_key  = '0;
        match_item = '0;
        for (int i = 0; i < CAPACITY; i++) begin
            if (is_tail[i]) begin
                tail_key  = tail_key | cell_key[i];
                tail_item = tail_item | cell_item[i];
                tail_eq   = tail_eq | cell_flags[i].eq;
            end
            if (first_eq[i]) begin
                match_key  = match_key | cell_key[i];
                match_item = match_item | cell_item[i];
            end
        end
    end

    assign empty = (r_count == '0);
    assign full  = (r_count == CNT_W'(CAPACITY));

    // request decoder: row move, response and new count
    always_comb begin
        ctl.mode   = MD_NONE;
        ctl.key    = r_key;
        ctl.item   = r_item;
        n_count    = r_count;
        n_status   = ST_OK;
        n_out_item = '0;
        n_out_key  = '0;
        unique case (r_op)
            REQ_PREPEND, REQ_APPEND: begin
                if (full) begin
                    n_status = ST_FULL;
                end else if (empty) begin
                    ctl.mode = MD_INS_ALL;
                    ctl.key  = '0;
                    n_count  = r_count + CNT_W'(1);
                end else if (r_op == REQ_PREPEND) begin
                    if (cell_key[0] == KEY_MIN) begin
                        n_status = ST_OVERFLOW;
                    end else begin
                        ctl.mode  = MD_INS_ALL;
                        ctl.key   = cell_key[0] - KEY_W'(1);
                        n_out_key = cell_key[0] - KEY_W'(1);
                        n_count   = r_count + CNT_W'(1);
                    end
                end else begin
                    if (tail_key == KEY_MAX) begin
                        n_status = ST_OVERFLOW;
                    end else begin
                        ctl.mode  = MD_INS_END;
                        ctl.key   = tail_key + KEY_W'(1);
                        n_out_key = tail_key + KEY_W'(1);
                        n_count   = r_count + CNT_W'(1);
                    end
                end
            end
            REQ_POP: begin
                if (empty) begin
                    n_status = ST_EMPTY;
                end else begin
                    ctl.mode   = MD_DEL_ALL;
                    n_out_item = cell_item[0];
                    n_out_key  = cell_key[0];
                    n_count    = r_count - CNT_W'(1);
                end
            end
            REQ_INSERT: begin
                if (full) begin
                    n_status = ST_FULL;
                end else begin
                    n_count = r_count + CNT_W'(1);
                    if (empty || cell_flags[0].gt) begin
                        ctl.mode = MD_INS_ALL;
                    end else if (!(|gt_vec)) begin
                        ctl.mode = MD_INS_END;
                    end else begin
                        ctl.mode = MD_INS_SORT;
                    end
                end
            end
            REQ_REMOVE: begin
                if (empty) begin
                    n_status = ST_EMPTY;
                end else if (cell_flags[0].eq) begin
                    ctl.mode   = MD_DEL_ALL;
                    n_out_item = cell_item[0];
                    n_out_key  = cell_key[0];
                    n_count    = r_count - CNT_W'(1);
                end else if (tail_eq) begin
                    ctl.mode   = MD_DEL_LAST;
                    n_out_item = tail_item;
                    n_out_key  = tail_key;
                    n_count    = r_count - CNT_W'(1);
                end else if (|eq_vec) begin
                    ctl.mode   = MD_DEL_FIRST;
                    n_out_item = match_item;
                    n_out_key  = match_key;
                    n_count    = r_count - CNT_W'(1);
                end else begin
                    n_status = ST_NOT_FOUND;
                end
            end
            default: begin
            end
        endcase
        if (!exec) begin
            ctl.mode = MD_NONE;
        end
    end

    // control and payload registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (accept) begin
                r_busy <= 1'b1;
            end else if (exec) begin
                r_busy <= 1'b0;
            end
            if (exec) begin
                r_count     <= n_count;
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
        end
        if (accept) begin
            r_op   <= i_req.req_type;
            r_item <= i_req.item_handle;
            r_key  <= i_req.req_key;
        end
        if (exec) begin
            r_status   <= n_status;
            r_out_item <= n_out_item;
            r_out_key  <= n_out_key;
        end
    end

    assign o_rsp.valid    = r_out_valid;
    assign o_rsp.status   = r_status;
    assign o_rsp.out_item = r_out_item;
    assign o_rsp.out_key  = r_out_key;

endmodule

`default_nettype wire

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 100ps
// tb_top: self-checking testbench for sorted_key_list, with a queue-based
// model of the sorted list and random valid/ready traffic on both channels.
// Depends on skl_pkg, skl_if and sorted_key_list.

module tb_top;
    import skl_pkg::*;

    localparam int LIST_DEPTH = 16;

    typedef struct packed {
        logic [STAT_W-1:0]       status;
        logic [ITEM_W-1:0]       item;
        logic signed [KEY_W-1:0] key;
    } t_rsp;

    logic i_clk = 1'b0;
    logic i_rst_n;

    skl_req_if req_if ();
    skl_rsp_if rsp_if ();

    sorted_key_list #(.CAPACITY(LIST_DEPTH)) dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (req_if),
        .o_rsp  (rsp_if)
    );

    // model of the list contents, index 0 is the head
    logic signed [KEY_W-1:0] list_keys[$];
    logic [ITEM_W-1:0]       list_items[$];
    // responses still owed by the block, oldest first
    t_rsp                    pending_rsp[$];

    bit   burst_mode;
    int   hold_req;
    int   stall_left;
    int   n_err;
    int   n_sent;
    int   n_checked;
    int   status_seen[8];
    t_rsp want;

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // apply one request to the model and return the response it owes
    function automatic t_rsp list_apply(input logic [OP_W-1:0] op,
                                        input logic [ITEM_W-1:0] item,
                                        input logic signed [KEY_W-1:0] key);
        t_rsp r;
        int   cnt;
        int   pos;
        bit   found;
        r     = '0;
        cnt   = list_keys.size();
        pos   = 0;
        found = 1'b0;
        case (op)
            REQ_PREPEND, REQ_APPEND: begin
                if (cnt >= LIST_DEPTH) begin
                    r.status = ST_FULL;
                end else if (cnt == 0) begin
                    list_keys.push_back('0);
                    list_items.push_back(item);
                end else if (op == REQ_PREPEND) begin
                    if (list_keys[0] == KEY_MIN) begin
                        r.status = ST_OVERFLOW;
                    end else begin
                        r.key = list_keys[0] - 32'sd1;
                        list_keys.push_front(r.key);
                        list_items.push_front(item);
                    end
                end else begin
                    if (list_keys[cnt-1] == KEY_MAX) begin
                        r.status = ST_OVERFLOW;
                    end else begin
                        r.key = list_keys[cnt-1] + 32'sd1;
                        list_keys.push_back(r.key);
                        list_items.push_back(item);
                    end
                end
            end
            REQ_POP: begin
                if (cnt == 0) begin
                    r.status = ST_EMPTY;
                end else begin
                    r.key  = list_keys.pop_front();
                    r.item = list_items.pop_front();
                end
            end
            REQ_INSERT: begin
                if (cnt >= LIST_DEPTH) begin
                    r.status = ST_FULL;
                end else begin
                    // below head goes first, not below tail goes last,
                    // else before the first entry after the head not below it
                    if (cnt == 0 || key < list_keys[0]) begin
                        pos = 0;
                    end else if (!(key < list_keys[cnt-1])) begin
                        pos = cnt;
                    end else begin
                        pos = cnt - 1;
                        for (int i = 1; i < cnt; i++) begin
                            if (!found && !(list_keys[i] < key)) begin
                                pos   = i;
                                found = 1'b1;
                            end
                        end
                    end
                    list_keys.insert(pos, key);
                    list_items.insert(pos, item);
                end
            end
            REQ_REMOVE: begin
                if (cnt == 0) begin
                    r.status = ST_EMPTY;
                end else begin
                    // head first, then tail, then earliest in between
                    if (list_keys[0] == key) begin
                        pos   = 0;
                        found = 1'b1;
                    end else if (list_keys[cnt-1] == key) begin
                        pos   = cnt - 1;
                        found = 1'b1;
                    end else begin
                        for (int i = 1; i < cnt - 1; i++) begin
                            if (!found && list_keys[i] == key) begin
                                pos   = i;
                                found = 1'b1;
                            end
                        end
                    end
                    if (!found) begin
                        r.status = ST_NOT_FOUND;
                    end else begin
                        r.key  = list_keys[pos];
                        r.item = list_items[pos];
                        list_keys.delete(pos);
                        list_items.delete(pos);
                    end
                end
            end
            default: ;
        endcase
        return r;
    endfunction

    // offer one request after a random gap, record its response on accept
    task automatic send_req(input logic [OP_W-1:0] op, input logic [ITEM_W-1:0] item,
                            input logic signed [KEY_W-1:0] key);
        int gap;
        gap = burst_mode ? 0 : $urandom_range(0, 10);
        if (gap > 0) begin
            req_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        req_if.valid       <= 1'b1;
        req_if.req_type    <= op;
        req_if.item_handle <= item;
        req_if.req_key     <= key;
        @(posedge i_clk);
        while (!req_if.ready) @(posedge i_clk);
        pending_rsp.push_back(list_apply(op, item, key));
        n_sent++;
    endtask

    // stop offering and wait for every owed response
    task automatic wait_drained();
        req_if.valid <= 1'b0;
        @(posedge i_clk);
        while (pending_rsp.size() != 0) @(posedge i_clk);
    endtask

    // key for a random request: mostly keys in the list for removes,
    // otherwise extremes, full-range values or a narrow band for ties
    function automatic logic signed [KEY_W-1:0] pick_key(input logic [OP_W-1:0] op);
        int sel;
        int cnt;
        sel = $urandom_range(0, 9);
        cnt = list_keys.size();
        if (cnt > 0 && sel < ((op == REQ_REMOVE) ? 7 : 3))
            return list_keys[$urandom_range(0, cnt - 1)];
        sel = $urandom_range(0, 9);
        case (sel)
            0:       return KEY_MIN + $urandom_range(0, 2);
            1:       return KEY_MAX - $urandom_range(0, 2);
            2, 3:    return $urandom();
            default: return $signed($urandom_range(0, 16)) - 32'sd8;
        endcase
    endfunction

    // response channel: random stall after each item, long holds on request
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            rsp_if.ready <= 1'b0;
            stall_left = 0;
        end else begin
            if (hold_req > 0) begin
                stall_left = hold_req;
                hold_req   = 0;
            end else if (rsp_if.valid && rsp_if.ready) begin
                stall_left = burst_mode ? 0 : $urandom_range(0, 10);
            end
            if (stall_left > 0) begin
                rsp_if.ready <= 1'b0;
                stall_left--;
            end else begin
                rsp_if.ready <= 1'b1;
            end
        end
    end

    // compare each accepted response with the oldest owed one
    always @(posedge i_clk) begin
        if (i_rst_n && rsp_if.valid && rsp_if.ready) begin
            if (pending_rsp.size() == 0) begin
                $error("response with none owed: status %0d item %h key %0d",
                       rsp_if.status, rsp_if.out_item, rsp_if.out_key);
                n_err++;
            end else begin
                want = pending_rsp.pop_front();
                n_checked++;
                status_seen[want.status]++;
                if (rsp_if.status !== want.status) begin
                    $error("status: expected %0d, got %0d", want.status, rsp_if.status);
                    n_err++;
                end
                if (rsp_if.out_item !== want.item) begin
                    $error("out_item: expected %h, got %h", want.item, rsp_if.out_item);
                    n_err++;
                end
                if (rsp_if.out_key !== want.key) begin
                    $error("out_key: expected %0d, got %0d", want.key, rsp_if.out_key);
                    n_err++;
                end
            end
        end
    end

    // empty list, key assignment, removal order, ties, overflow, unused codes
    task automatic test_directed();
        send_req(REQ_POP,     32'h1, 32'sd0);
        send_req(REQ_REMOVE,  32'h2, 32'sd0);
        send_req(REQ_PREPEND, 32'h0, 32'sd0);
        send_req(REQ_APPEND,  32'hFFFF_FFFF, 32'sd0);
        send_req(REQ_PREPEND, 32'h3, 32'sd0);
        send_req(REQ_REMOVE,  32'h4, 32'sd5);
        send_req(REQ_REMOVE,  32'h5, 32'sd0);
        send_req(REQ_REMOVE,  32'h6, -32'sd1);
        // only entry left
        send_req(REQ_REMOVE,  32'h7, 32'sd1);
        send_req(REQ_INSERT,  32'h8, KEY_MAX);
        send_req(REQ_APPEND,  32'h9, 32'sd0);
        send_req(REQ_INSERT,  32'hA, KEY_MIN);
        send_req(REQ_PREPEND, 32'hB, 32'sd0);
        // ties: at the tail, in the middle, at the head
        send_req(REQ_INSERT,  32'hC, KEY_MAX);
        send_req(REQ_INSERT,  32'hD, 32'sd0);
        send_req(REQ_INSERT,  32'hE, 32'sd0);
        send_req(REQ_INSERT,  32'hF, KEY_MIN);
        send_req(REQ_REMOVE,  32'h10, KEY_MAX);
        send_req(REQ_REMOVE,  32'h11, 32'sd0);
        send_req(REQ_POP,     32'h12, 32'sd0);
        for (int k = 1; k <= 3; k++)
            send_req(OP_W'(REQ_REMOVE + k), 32'hFFFF_FFFF, -32'sd1);
        wait_drained();
    endtask

    // receiver holds off while the sender keeps offering
    task automatic test_backpressure();
        burst_mode = 1'b1;
        hold_req   = 80;
        for (int k = 0; k < 10; k++)
            send_req((k % 2 == 0) ? REQ_INSERT : REQ_APPEND, $urandom(), pick_key(REQ_INSERT));
        burst_mode = 1'b0;
        wait_drained();
    endtask

    // alternating grow and shrink phases so full and empty are both reached
    task automatic test_random_ops(input int n_items);
        bit                      grow;
        int                      sel;
        logic [OP_W-1:0]         op;
        grow = 1'b1;
        for (int k = 0; k < n_items; k++) begin
            if (list_keys.size() >= LIST_DEPTH && $urandom_range(0, 2) == 0)
                grow = 1'b0;
            else if (list_keys.size() == 0 && $urandom_range(0, 1) == 0)
                grow = 1'b1;
            else if ($urandom_range(0, 39) == 0)
                grow = !grow;
            sel = $urandom_range(0, 99);
            if (grow) begin
                if (sel < 18)      op = REQ_PREPEND;
                else if (sel < 36) op = REQ_APPEND;
                else if (sel < 76) op = REQ_INSERT;
                else if (sel < 84) op = REQ_POP;
                else if (sel < 97) op = REQ_REMOVE;
                else               op = OP_W'(REQ_REMOVE + $urandom_range(1, 3));
            end else begin
                if (sel < 8)       op = REQ_PREPEND;
                else if (sel < 16) op = REQ_APPEND;
                else if (sel < 30) op = REQ_INSERT;
                else if (sel < 62) op = REQ_POP;
                else if (sel < 97) op = REQ_REMOVE;
                else               op = OP_W'(REQ_REMOVE + $urandom_range(1, 3));
            end
            send_req(op, $urandom(), pick_key(op));
        end
        wait_drained();
    endtask

    // back-to-back items with no idling on either side
    task automatic test_burst(input int n_items);
        burst_mode = 1'b1;
        test_random_ops(n_items);
        burst_mode = 1'b0;
    endtask

    initial begin
        i_rst_n            <= 1'b0;
        req_if.valid       <= 1'b0;
        req_if.req_type    <= REQ_PREPEND;
        req_if.item_handle <= '0;
        req_if.req_key     <= '0;
        burst_mode = 1'b0;
        hold_req   = 0;
        n_err      = 0;
        n_sent     = 0;
        n_checked  = 0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        test_backpressure();
        test_random_ops(600);
        test_burst(80);

        // latency tail: nothing more may arrive
        repeat (10) @(posedge i_clk);
        if (pending_rsp.size() != 0) begin
            $error("%0d responses never arrived", pending_rsp.size());
            n_err++;
        end
        $display("run: %0d requests sent, %0d responses checked, %0d errors",
                 n_sent, n_checked, n_err);
        $display("run: ok %0d, empty %0d, not found %0d, full %0d, overflow %0d",
                 status_seen[ST_OK], status_seen[ST_EMPTY], status_seen[ST_NOT_FOUND],
                 status_seen[ST_FULL], status_seen[ST_OVERFLOW]);
        if (n_err == 0) begin
            $display("tb_top: PASS");
        end else begin
            $display("tb_top: FAIL");
        end
        $finish;
    end

    // watchdog
    initial begin
        #2_000_000;
        $display("tb_top: FAIL");
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/core/skl_pkg.sv
rtl/core/skl_if.sv
rtl/core/skl_cell.sv
rtl/core/sorted_key_list.sv
tb/sv/tb_top.sv
